>>> sv/oklt_pkg.sv
// ----------------------------------------------------------------------------
// oklt_pkg
// Shared types and codes for the ordered key list table: request and status
// codes, channel words, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oklt_pkg;

  // default list capacity
  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 5;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_HEAD    = 3'd0,
    REQ_TAIL    = 3'd1,
    REQ_ORDERED = 3'd2,
    REQ_DELETE  = 3'd3,
    REQ_DUMP    = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  // request word
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key;
  } req_word_t;

  // result word
  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic                    last;
    logic [STAT_W-1:0]       status;
    logic [FILL_W-1:0]       fill_count;
    logic                    is_empty;
  } rsp_word_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RESP,
    S_DUMP,
    S_ROT
  } state_e;

  // datapath operation on the cell row
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_CLEAR,
    OP_ROTATE
  } dp_op_e;

  // where an insert lands
  typedef enum logic [1:0] {
    MODE_HEAD,
    MODE_TAIL,
    MODE_ORDERED
  } ins_mode_e;

  // controller to datapath
  typedef struct packed {
    logic      load_key;
    dp_op_e    op;
    ins_mode_e mode;
    logic      load_status;
    status_e   status_val;
    logic      load_out;
    logic      out_dump;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic found;
    logic empty;
    logic dump_last;
    logic rot_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/ordered_key_list_table.sv
// Sequence: a non-dump request is accepted while idle, updates the list in the next
// cycle and shows its result word once the result channel is free; req_stall holds
// off the next request until the block is idle again. Dump of a non-empty list: one
// key a cycle from the head while the result is not stalled, then the cell row finishes
// a full turn; an empty dump returns a single empty-status word. Reset (rst, synchronous)
// empties the list and drops any pending result word.
// ----------------------------------------------------------------------------
// ordered_key_list_table
// Bounded list of signed keys kept head to tail: head, tail and ordered
// insert, delete by key, dump and clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_list_table #(
  parameter int unsigned DEPTH = oklt_pkg::DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire oklt_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output oklt_pkg::rsp_word_t      rsp
);
  import oklt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  oklt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req.req_type),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // cell row and result register
  oklt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .key  (req.key),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

>>> sv/oklt_ctrl.sv
// ----------------------------------------------------------------------------
// oklt_ctrl
// Sequencer for the key list: takes a request, steers one update of the
// cell row, then issues the single result or streams a dump.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oklt_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire logic [oklt_pkg::REQ_W-1:0] req_type,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output oklt_pkg::dp_cmd_t            cmd,
  input  wire oklt_pkg::dp_stat_t      stat
);
  import oklt_pkg::*;

  state_e           state;
  state_e           state_next;
  logic [REQ_W-1:0] req_q;
  logic             out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // held request code
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      req_q <= req_type;
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.op           = OP_NONE;
    cmd.mode         = MODE_HEAD;
    cmd.status_val   = STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_key = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.load_status = 1'b1;
        state_next      = S_RESP;
        unique case (req_q)
          REQ_HEAD, REQ_TAIL, REQ_ORDERED: begin
            if (stat.full) begin
              cmd.status_val = STAT_FULL;
            end else begin
              cmd.op = OP_INSERT;
              unique case (req_q)
                REQ_HEAD: cmd.mode = MODE_HEAD;
                REQ_TAIL: cmd.mode = MODE_TAIL;
                default:  cmd.mode = MODE_ORDERED;
              endcase
            end
          end
          REQ_DELETE: begin
            cmd.op         = OP_DELETE;
            cmd.status_val = stat.found ? STAT_OK : STAT_NOT_FOUND;
          end
          REQ_DUMP: begin
            if (stat.empty) begin
              cmd.status_val = STAT_EMPTY;
            end else begin
              state_next = S_DUMP;
            end
          end
          REQ_CLEAR: begin
            cmd.op = OP_CLEAR;
          end
          default: begin
            // unused codes: no change, plain ok result
          end
        endcase
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUMP: begin
        // head key out, row turns by one
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_dump = 1'b1;
          cmd.op       = OP_ROTATE;
          if (stat.dump_last) begin
            state_next = stat.rot_done ? S_IDLE : S_ROT;
          end
        end
      end
      S_ROT: begin
        // finish the full turn so the head is back in place
        cmd.op = OP_ROTATE;
        if (stat.rot_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/oklt_dp.sv
// ----------------------------------------------------------------------------
// oklt_dp
// Row of key cells with per-cell compare and shift, fill count, step
// counter for dumps, and the result word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oklt_dp #(
  parameter int unsigned DEPTH = oklt_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic signed [oklt_pkg::KEY_W-1:0] key,
  input  wire oklt_pkg::dp_cmd_t               cmd,
  output oklt_pkg::dp_stat_t                   stat,
  output oklt_pkg::rsp_word_t                  rsp
);
  import oklt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [KEY_W-1:0] key_q;
  logic [KEY_W-1:0]        cells [DEPTH];
  logic [KEY_W-1:0]        up_val [DEPTH];
  logic [KEY_W-1:0]        dn_val [DEPTH];
  logic [CW-1:0]           count;
  logic [CW-1:0]           step;
  status_e                 status_q;

  logic [DEPTH-1:0] mark;
  logic [DEPTH-1:0] mark_low;
  logic [DEPTH-1:0] mark_above;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] eq_low;
  logic [DEPTH-1:0] eq_above;
  logic [DEPTH-1:0] del_move;

  // neighbour taps for each cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == DEPTH - 1) begin : g_end
      assign up_val[i] = cells[0];
    end else begin : g_mid
      assign up_val[i] = cells[i+1];
    end
    if (i == 0) begin : g_first
      assign dn_val[i] = key_q;
    end else begin : g_rest
      assign dn_val[i] = cells[i-1];
    end
  end

  // per-cell insert mark and key match
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      unique case (cmd.mode)
        MODE_HEAD: mark[i] = 1'b1;
        MODE_TAIL: mark[i] = (CW'(i) >= count);
        default:   mark[i] = (CW'(i) >= count) || !($signed(cells[i]) < key_q);
      endcase
      eq[i] = (CW'(i) < count) && (cells[i] == key_q);
    end
  end

  // first hit and everything past it, by borrow chain
  assign mark_low   = mark & (mark ^ (mark - DEPTH'(1)));
  assign mark_above = ~(mark ^ (mark - DEPTH'(1)));
  assign eq_low     = eq & (eq ^ (eq - DEPTH'(1)));
  assign eq_above   = ~(eq ^ (eq - DEPTH'(1)));
  assign del_move   = eq_low | eq_above;

  // status to the controller
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.found     = |eq;
  assign stat.empty     = (count == '0);
  assign stat.dump_last = (step == count - CW'(1));
  assign stat.rot_done  = (step == CW'(DEPTH - 1));

  // request key
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_q <= key;
    end
  end

  // cell row
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (mark_above[i]) begin
            cells[i] <= dn_val[i];
          end else if (mark_low[i]) begin
            cells[i] <= key_q;
          end
        end
        OP_DELETE: begin
          if (del_move[i]) begin
            cells[i] <= up_val[i];
          end
        end
        OP_ROTATE: cells[i] <= up_val[i];
        default: ;
      endcase
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.op)
        OP_INSERT: count <= count + CW'(1);
        OP_DELETE: begin
          if (stat.found) begin
            count <= count - CW'(1);
          end
        end
        OP_CLEAR:  count <= '0;
        default: ;
      endcase
    end
  end

  // rotation step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load_key) begin
      step <= '0;
    end else if (cmd.op == OP_ROTATE) begin
      step <= step + CW'(1);
    end
  end

  // held status
  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      status_q <= cmd.status_val;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.fill_count <= FILL_W'(count);
      rsp.is_empty   <= (count == '0);
      if (cmd.out_dump) begin
        rsp.out_key <= cells[0];
        rsp.last    <= stat.dump_last;
        rsp.status  <= STAT_OK;
      end else begin
        rsp.out_key <= '0;
        rsp.last    <= 1'b1;
        rsp.status  <= status_q;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/oklt_checker.sv
// ----------------------------------------------------------------------------
// oklt_checker
// Port-level checks on the key list table's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oklt_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire oklt_pkg::rsp_word_t rsp
);
  import oklt_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // no result straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // empty flag agrees with fill
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.fill_count == '0)))
    else $error("empty flag disagrees with fill");

  // only an ok word may carry a key and a non-final mark
  a_nonok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STAT_OK) |-> rsp.last && (rsp.out_key == '0))
    else $error("error result carries key or misses last");

  // empty status only on an empty list
  a_empty_stat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STAT_EMPTY) |-> rsp.is_empty)
    else $error("empty status with entries held");

endmodule

bind ordered_key_list_table oklt_checker u_oklt_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
